// ----- src/crr_pkg.sv -----
// ----------------------------------------------------------------------------
// Caesar request responder package
// Shared types, codes and small arithmetic helpers for the responder core.
// ----------------------------------------------------------------------------
package crr_pkg;

    // Result kinds.
    typedef enum logic {
        KIND_BYTE    = 1'b0,
        KIND_SUMMARY = 1'b1
    } crr_kind_t;

    // Summary status codes.
    typedef enum logic [1:0] {
        STATUS_OK            = 2'd0,
        STATUS_BAD_OP        = 2'd1,
        STATUS_CSUM_MISMATCH = 2'd2,
        STATUS_BAD_LENGTH    = 2'd3
    } crr_status_t;

    // Operation codes carried in the first header byte.
    localparam logic [7:0] OP_ENCODE = 8'd0;
    localparam logic [7:0] OP_DECODE = 8'd1;

    // Header byte positions.
    localparam logic [2:0] HDR_OP      = 3'd0;
    localparam logic [2:0] HDR_SHIFT   = 3'd1;
    localparam logic [2:0] HDR_CSUM_HI = 3'd2;
    localparam logic [2:0] HDR_CSUM_LO = 3'd3;
    localparam logic [2:0] HDR_LEN_0   = 3'd4;
    localparam logic [2:0] HDR_LEN_1   = 3'd5;
    localparam logic [2:0] HDR_LEN_2   = 3'd6;
    localparam logic [2:0] HDR_LEN_3   = 3'd7;

    // Header counter value meaning the payload phase.
    localparam logic [3:0] HDR_PAYLOAD = 4'd8;

    localparam logic [31:0] HEADER_BYTES       = 32'd8;
    localparam logic [31:0] MAX_LENGTH_DEFAULT = 32'd10000000;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;
    localparam logic [5:0] ALPHABET     = 6'd26;

    typedef struct packed {
        crr_kind_t   kind;
        logic [7:0]  data;
        crr_status_t status;
        logic [15:0] checksum;
        logic        last;
    } crr_result_t;

    // Up to two results produced by one accepted byte.
    typedef struct packed {
        logic        first_valid;
        logic        second_valid;
        crr_result_t first;
        crr_result_t second;
    } crr_push_t;

    // 16-bit one's-complement addition with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // Lowercase, then rotate letters by key. A key of zero passes the byte through.
    function automatic logic [7:0] rotate_byte(input logic [7:0] b, input logic [4:0] key);
        logic [7:0] lower;
        logic [7:0] offset;
        logic [5:0] sum;
        logic [7:0] result;
        lower  = ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) ? (b + CASE_OFFSET) : b;
        offset = lower - CHAR_LOWER_A;
        sum    = {1'b0, offset[4:0]} + {1'b0, key};
        if (sum >= ALPHABET)
        begin
            sum = sum - ALPHABET;
        end
        result = lower;
        if ((lower >= CHAR_LOWER_A) && (lower <= CHAR_LOWER_Z))
        begin
            result = CHAR_LOWER_A + {2'b00, sum};
        end
        if (key == 5'd0)
        begin
            result = b;
        end
        return result;
    endfunction

    // Signed shift taken modulo 26 into 0..25; decode uses 26 minus that.
    // The shift is biased by 130 (five alphabets) so the value is positive,
    // then divided by 26 through a reciprocal that may fall one short.
    function automatic logic [4:0] shift_key(input logic [7:0] shift, input logic decode);
        logic [8:0]  v;
        logic [17:0] prod;
        logic [8:0]  q;
        logic [8:0]  r;
        logic [4:0]  m;
        v    = shift[7] ? ({1'b0, shift} - 9'd126) : ({1'b0, shift} + 9'd130);
        prod = {9'd0, v} * 18'd315;
        q    = {4'd0, prod[17:13]};
        r    = v - (q * 9'd26);
        if (r >= {3'd0, ALPHABET})
        begin
            r = r - {3'd0, ALPHABET};
        end
        m = r[4:0];
        return decode ? (ALPHABET[4:0] - m) : m;
    endfunction

    // End-of-message summary from the final sums.
    function automatic crr_result_t make_finish(input logic [15:0] req_sum,
                                                input logic [15:0] resp_sum,
                                                input logic [15:0] received);
        crr_result_t res;
        res.kind     = KIND_SUMMARY;
        res.data     = 8'd0;
        res.last     = 1'b1;
        if (~req_sum != received)
        begin
            res.status   = STATUS_CSUM_MISMATCH;
            res.checksum = 16'd0;
        end
        else
        begin
            res.status   = STATUS_OK;
            res.checksum = ~resp_sum;
        end
        return res;
    endfunction

    function automatic crr_result_t make_error(input crr_status_t status);
        crr_result_t res;
        res.kind     = KIND_SUMMARY;
        res.data     = 8'd0;
        res.status   = status;
        res.checksum = 16'd0;
        res.last     = 1'b1;
        return res;
    endfunction

endpackage

// ----- src/crr_engine.sv -----
// ----------------------------------------------------------------------------
// Caesar request responder engine
// Header parser, Caesar transform and checksum accumulators; one byte a cycle.
// ----------------------------------------------------------------------------
module crr_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        request_byte,
    input  logic [31:0]       max_message_length,
    output crr_pkg::crr_push_t push
);
    import crr_pkg::*;

    logic [3:0]  header_count_reg, header_count_next;
    logic [7:0]  op_code_reg, op_code_next;
    logic [4:0]  caesar_key_reg, caesar_key_next;
    logic [15:0] received_checksum_reg, received_checksum_next;
    logic [23:0] length_reg, length_next;
    logic [31:0] bytes_remaining_reg, bytes_remaining_next;
    logic [15:0] request_sum_reg, request_sum_next;
    logic [15:0] response_sum_reg, response_sum_next;
    logic [7:0]  held_request_reg, held_request_next;
    logic [7:0]  held_response_reg, held_response_next;
    logic        odd_phase_reg, odd_phase_next;

    logic [7:0]  rotated;
    logic [15:0] word_req;
    logic [15:0] word_resp;
    logic [15:0] add_req;
    logic [15:0] add_resp;
    logic [31:0] full_length;
    logic [15:0] header_sum;
    logic        final_byte;

    assign rotated     = rotate_byte(request_byte, caesar_key_reg);
    // An odd final byte is the high half of a word whose low half is zero.
    assign word_req    = odd_phase_reg ? {held_request_reg, request_byte} : {request_byte, 8'd0};
    assign word_resp   = odd_phase_reg ? {held_response_reg, rotated} : {rotated, 8'd0};
    assign add_req     = oc_add(request_sum_reg, word_req);
    assign add_resp    = oc_add(response_sum_reg, word_resp);
    assign full_length = {length_reg, request_byte};
    assign header_sum  = oc_add(request_sum_reg, {length_reg[7:0], request_byte});
    assign final_byte  = (bytes_remaining_reg == 32'd1);

    always_comb
    begin
        header_count_next      = header_count_reg;
        op_code_next           = op_code_reg;
        caesar_key_next        = caesar_key_reg;
        received_checksum_next = received_checksum_reg;
        length_next            = length_reg;
        bytes_remaining_next   = bytes_remaining_reg;
        request_sum_next       = request_sum_reg;
        response_sum_next      = response_sum_reg;
        held_request_next      = held_request_reg;
        held_response_next     = held_response_reg;
        odd_phase_next         = odd_phase_reg;
        push                   = '0;

        if (take)
        begin
            if (header_count_reg[3])
            begin
                push.first_valid     = 1'b1;
                push.first.kind      = KIND_BYTE;
                push.first.data      = rotated;
                push.first.status    = STATUS_OK;
                push.first.checksum  = 16'd0;
                push.first.last      = ~final_byte;
                bytes_remaining_next = bytes_remaining_reg - 32'd1;
                if (final_byte)
                begin
                    push.second_valid = 1'b1;
                    push.second       = make_finish(add_req, add_resp, received_checksum_reg);
                    header_count_next = 4'd0;
                    odd_phase_next    = 1'b0;
                end
                else if (odd_phase_reg)
                begin
                    request_sum_next  = add_req;
                    response_sum_next = add_resp;
                    odd_phase_next    = 1'b0;
                end
                else
                begin
                    held_request_next  = request_byte;
                    held_response_next = rotated;
                    odd_phase_next     = 1'b1;
                end
            end
            else
            begin
                header_count_next = header_count_reg + 4'd1;
                unique case (header_count_reg[2:0])
                    HDR_OP:
                    begin
                        op_code_next = request_byte;
                    end
                    HDR_SHIFT:
                    begin
                        caesar_key_next  = shift_key(request_byte, op_code_reg == OP_DECODE);
                        request_sum_next = {op_code_reg, request_byte};
                    end
                    HDR_CSUM_HI:
                    begin
                        received_checksum_next = {request_byte, 8'd0};
                    end
                    HDR_CSUM_LO:
                    begin
                        received_checksum_next = {received_checksum_reg[15:8], request_byte};
                    end
                    HDR_LEN_0:
                    begin
                        length_next = {16'd0, request_byte};
                    end
                    HDR_LEN_1:
                    begin
                        length_next      = {length_reg[15:0], request_byte};
                        request_sum_next = oc_add(request_sum_reg,
                                                  {length_reg[7:0], request_byte});
                    end
                    HDR_LEN_2:
                    begin
                        length_next = {length_reg[15:0], request_byte};
                    end
                    HDR_LEN_3:
                    begin
                        header_count_next = 4'd0;
                        priority if ((op_code_reg != OP_ENCODE) && (op_code_reg != OP_DECODE))
                        begin
                            push.first_valid = 1'b1;
                            push.first       = make_error(STATUS_BAD_OP);
                        end
                        else if ((full_length < HEADER_BYTES)
                                 || (full_length > max_message_length))
                        begin
                            push.first_valid = 1'b1;
                            push.first       = make_error(STATUS_BAD_LENGTH);
                        end
                        else if (full_length == HEADER_BYTES)
                        begin
                            push.first_valid     = 1'b1;
                            push.first           = make_finish(header_sum, header_sum,
                                                               received_checksum_reg);
                            bytes_remaining_next = 32'd0;
                            odd_phase_next       = 1'b0;
                        end
                        else
                        begin
                            header_count_next    = HDR_PAYLOAD;
                            bytes_remaining_next = full_length - HEADER_BYTES;
                            request_sum_next     = header_sum;
                            response_sum_next    = header_sum;
                            held_request_next    = 8'd0;
                            held_response_next   = 8'd0;
                            odd_phase_next       = 1'b0;
                        end
                    end
                    default:
                    begin
                        header_count_next = header_count_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg      <= 4'd0;
            op_code_reg           <= 8'd0;
            caesar_key_reg        <= 5'd0;
            received_checksum_reg <= 16'd0;
            length_reg            <= 24'd0;
            bytes_remaining_reg   <= 32'd0;
            request_sum_reg       <= 16'd0;
            response_sum_reg      <= 16'd0;
            held_request_reg      <= 8'd0;
            held_response_reg     <= 8'd0;
            odd_phase_reg         <= 1'b0;
        end
        else
        begin
            header_count_reg      <= header_count_next;
            op_code_reg           <= op_code_next;
            caesar_key_reg        <= caesar_key_next;
            received_checksum_reg <= received_checksum_next;
            length_reg            <= length_next;
            bytes_remaining_reg   <= bytes_remaining_next;
            request_sum_reg       <= request_sum_next;
            response_sum_reg      <= response_sum_next;
            held_request_reg      <= held_request_next;
            held_response_reg     <= held_response_next;
            odd_phase_reg         <= odd_phase_next;
        end
    end

endmodule

// ----- src/crr_result_fifo.sv -----
// ----------------------------------------------------------------------------
// Caesar request responder result queue
// Small register queue taking up to two results a cycle and giving one.
// ----------------------------------------------------------------------------
module crr_result_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  crr_pkg::crr_push_t   push,
    output logic                 pair_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output crr_pkg::crr_result_t out_result
);
    import crr_pkg::*;

    localparam int AW = $clog2(DEPTH);

    crr_result_t    mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW:0]    count_reg, count_next;
    logic           pop;

    // Stall the producer unless two entries are free.
    assign pair_stall = (count_reg > (AW+1)'(DEPTH - 2));
    assign out_valid  = (count_reg != '0);
    assign out_result = mem_reg[rd_ptr_reg];
    assign pop        = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + {{(AW-1){1'b0}}, push.first_valid}
                                 + {{(AW-1){1'b0}}, push.second_valid};
        rd_ptr_next = rd_ptr_reg + {{(AW-1){1'b0}}, pop};
        count_next  = count_reg + {{AW{1'b0}}, push.first_valid}
                                + {{AW{1'b0}}, push.second_valid}
                                - {{AW{1'b0}}, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.first_valid)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.second_valid)
        begin
            mem_reg[wr_ptr_reg + {{(AW-1){1'b0}}, 1'b1}] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/caesar_request_responder_core.sv -----
// ----------------------------------------------------------------------------
// Caesar request responder core
// Parses request headers, Caesar-transforms the payload and reports checksums.
// ----------------------------------------------------------------------------
// The core accepts one request byte per clock cycle. Each request opens with
// an eight-byte header (op, signed shift, big-endian checksum, big-endian
// 32-bit total length); every payload byte is returned at once as a
// transformed byte result, and the last payload byte is followed by a summary
// result carrying the status and the response checksum. A header with a bad
// op or a bad length produces a summary as soon as its last byte arrives. Each
// byte is handled combinationally by the engine and its results are written
// straight into a small result queue, which gives one result transfer per
// cycle unless the receiver stalls; a result is offered from the queue's
// registers once the results ahead of it have gone. Input is taken in every
// cycle in which the queue has two free entries; a message with N payload
// bytes gives N + 1 results. When the results are drained every cycle the
// queue never holds more than two entries and the input side never stalls;
// it stalls only while fewer than two entries are free. The max_message_length
// register resets to 10000000 and must only be written while the core is idle.
// ----------------------------------------------------------------------------
module caesar_request_responder_core #(
    // Result queue depth: a power of two, at least four.
    parameter int FIFO_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write_en,
    input  logic [31:0] cfg_write_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  request_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        out_kind,
    output logic [7:0]  out_byte,
    output logic [1:0]  out_status,
    output logic [15:0] out_checksum,
    output logic        out_last
);
    import crr_pkg::*;

    logic [31:0] max_length_reg, max_length_next;
    logic        take;
    crr_push_t   push;
    crr_result_t result;

    // The single configuration register; written whenever the enable is high.
    assign max_length_next = cfg_write_en ? cfg_write_data : max_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_DEFAULT;
        end
        else
        begin
            max_length_reg <= max_length_next;
        end
    end

    // A byte transfer completes when the queue can take both possible results.
    assign take = in_valid && !in_stall;

    crr_engine u_engine (
        .clk                (clk),
        .rst_n              (rst_n),
        .take               (take),
        .request_byte       (request_byte),
        .max_message_length (max_length_reg),
        .push               (push)
    );

    crr_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pair_stall (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (result)
    );

    assign out_kind     = result.kind;
    assign out_byte     = result.data;
    assign out_status   = result.status;
    assign out_checksum = result.checksum;
    assign out_last     = result.last;

    // The engine only produces results for a byte it has actually accepted.
    a_push_needs_take: assert property (@(posedge clk) disable iff (!rst_n)
        (push.first_valid || push.second_valid) |-> take)
        else $error("results pushed without an accepted byte");

    // A second result is always the summary following a final payload byte.
    a_second_is_summary: assert property (@(posedge clk) disable iff (!rst_n)
        push.second_valid |-> (push.first_valid && push.first.kind == KIND_BYTE
                               && !push.first.last && push.second.kind == KIND_SUMMARY))
        else $error("malformed result pair");

    // A summary always closes the results of its byte.
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind == KIND_SUMMARY) |-> out_last)
        else $error("summary without last flag");

    // A failing status never reports a response checksum.
    a_error_no_checksum: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_status != STATUS_OK) |-> (out_checksum == 16'd0))
        else $error("checksum reported with failing status");

endmodule

// ----- test/crr_response_checker.sv -----
// ----------------------------------------------------------------------------
// Caesar request responder response checker
// Follows the request stream and configuration writes, predicts every result
// of the responder core and compares each output transfer field by field.
// ----------------------------------------------------------------------------
module crr_response_checker (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write_en,
    input  logic [31:0] cfg_write_data,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  request_byte,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        out_kind,
    input  logic [7:0]  out_byte,
    input  logic [1:0]  out_status,
    input  logic [15:0] out_checksum,
    input  logic        out_last,

    output int          error_count,
    output int          expected_count
);
    import crr_pkg::*;

    // Shadow of the core's message state.
    logic [3:0]  hdr_pos      = '0;
    logic [7:0]  op_byte      = '0;
    logic [7:0]  shift_byte   = '0;
    logic [4:0]  rot_key      = '0;
    logic [15:0] rx_csum      = '0;
    logic [31:0] total_len    = '0;
    logic [31:0] bytes_left   = '0;
    logic [15:0] req_sum      = '0;
    logic [15:0] resp_sum     = '0;
    logic [7:0]  held_req     = '0;
    logic [7:0]  held_resp    = '0;
    logic        odd_byte     = 1'b0;
    logic [31:0] length_limit = MAX_LENGTH_DEFAULT;

    crr_result_t predicted_responses[$];

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        int unsigned s;
        s = a + b;
        s = (s & 32'hFFFF) + (s >> 16);
        return s[15:0];
    endfunction

    function automatic logic [7:0] caesar_map(input logic [7:0] b, input logic [4:0] key);
        int c;
        c = b;
        if (key == 5'd0)
        begin
            return b;
        end
        if (c >= int'(CHAR_UPPER_A) && c <= int'(CHAR_UPPER_Z))
        begin
            c = c + int'(CASE_OFFSET);
        end
        if (c >= int'(CHAR_LOWER_A) && c <= int'(CHAR_LOWER_Z))
        begin
            c = int'(CHAR_LOWER_A) + (c - int'(CHAR_LOWER_A) + int'(key)) % 26;
        end
        return c[7:0];
    endfunction

    function automatic logic [4:0] shift_to_key(input logic [7:0] shift, input logic decode);
        int s;
        int k;
        s = int'($signed(shift));
        k = ((s % 26) + 26) % 26;
        if (decode)
        begin
            k = 26 - k;
        end
        return k[4:0];
    endfunction

    function void queue_result(input crr_kind_t kind, input logic [7:0] data,
                               input crr_status_t status, input logic [15:0] csum,
                               input logic last);
        crr_result_t r;
        r.kind     = kind;
        r.data     = data;
        r.status   = status;
        r.checksum = csum;
        r.last     = last;
        predicted_responses.push_back(r);
    endfunction

    // Closes the message: an odd trailing byte is padded with a zero low byte.
    function void close_message();
        logic [15:0] rq;
        logic [15:0] rs;
        rq = req_sum;
        rs = resp_sum;
        if (odd_byte)
        begin
            rq = ones_add(rq, {held_req, 8'h00});
            rs = ones_add(rs, {held_resp, 8'h00});
        end
        if (~rq != rx_csum)
        begin
            queue_result(KIND_SUMMARY, 8'd0, STATUS_CSUM_MISMATCH, 16'd0, 1'b1);
        end
        else
        begin
            queue_result(KIND_SUMMARY, 8'd0, STATUS_OK, ~rs, 1'b1);
        end
        hdr_pos    = '0;
        bytes_left = '0;
        odd_byte   = 1'b0;
    endfunction

    function void transform_request_byte(input logic [7:0] b);
        logic [7:0] t;
        if (hdr_pos >= HDR_PAYLOAD)
        begin
            t = caesar_map(b, rot_key);
            if (odd_byte)
            begin
                req_sum  = ones_add(req_sum, {held_req, b});
                resp_sum = ones_add(resp_sum, {held_resp, t});
                odd_byte = 1'b0;
            end
            else
            begin
                held_req  = b;
                held_resp = t;
                odd_byte  = 1'b1;
            end
            bytes_left = bytes_left - 1;
            if (bytes_left == 0)
            begin
                queue_result(KIND_BYTE, t, STATUS_OK, 16'd0, 1'b0);
                close_message();
            end
            else
            begin
                queue_result(KIND_BYTE, t, STATUS_OK, 16'd0, 1'b1);
            end
            return;
        end

        case (hdr_pos[2:0])
            HDR_OP:      op_byte = b;
            HDR_SHIFT:   shift_byte = b;
            HDR_CSUM_HI: rx_csum = {b, 8'h00};
            HDR_CSUM_LO: rx_csum[7:0] = b;
            default:     total_len = {total_len[23:0], b};
        endcase
        hdr_pos = hdr_pos + 4'd1;
        if (hdr_pos != HDR_PAYLOAD)
        begin
            return;
        end

        if (op_byte != OP_ENCODE && op_byte != OP_DECODE)
        begin
            hdr_pos = '0;
            queue_result(KIND_SUMMARY, 8'd0, STATUS_BAD_OP, 16'd0, 1'b1);
        end
        else if (total_len < HEADER_BYTES || total_len > length_limit)
        begin
            hdr_pos = '0;
            queue_result(KIND_SUMMARY, 8'd0, STATUS_BAD_LENGTH, 16'd0, 1'b1);
        end
        else
        begin
            rot_key    = shift_to_key(shift_byte, op_byte == OP_DECODE);
            req_sum    = ones_add(16'd0, {op_byte, shift_byte});
            req_sum    = ones_add(req_sum, total_len[31:16]);
            req_sum    = ones_add(req_sum, total_len[15:0]);
            resp_sum   = req_sum;
            held_req   = '0;
            held_resp  = '0;
            odd_byte   = 1'b0;
            bytes_left = total_len - HEADER_BYTES;
            if (bytes_left == 0)
            begin
                close_message();
            end
        end
    endfunction

    function void check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            error_count++;
        end
    endfunction

    function void check_response();
        crr_result_t want;
        if (predicted_responses.size() == 0)
        begin
            $display({"%0t: result with nothing expected, actual kind %0d byte 0x%0h",
                      " status %0d checksum 0x%0h last %0d"},
                     $time, out_kind, out_byte, out_status, out_checksum, out_last);
            error_count++;
            return;
        end
        want = predicted_responses.pop_front();
        check_field("out_kind", 16'(want.kind), 16'(out_kind));
        check_field("out_byte", 16'(want.data), 16'(out_byte));
        check_field("out_status", 16'(want.status), 16'(out_status));
        check_field("out_checksum", want.checksum, out_checksum);
        check_field("out_last", 16'(want.last), 16'(out_last));
    endfunction

    // Results are compared before the byte of the same edge is predicted, since
    // no byte can produce a result in the cycle in which it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos      = '0;
            op_byte      = '0;
            shift_byte   = '0;
            rot_key      = '0;
            rx_csum      = '0;
            total_len    = '0;
            bytes_left   = '0;
            req_sum      = '0;
            resp_sum     = '0;
            held_req     = '0;
            held_resp    = '0;
            odd_byte     = 1'b0;
            length_limit = MAX_LENGTH_DEFAULT;
            error_count  = 0;
            predicted_responses.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_response();
            end
            if (cfg_write_en)
            begin
                length_limit = cfg_write_data;
            end
            if (in_valid && !in_stall)
            begin
                transform_request_byte(request_byte);
            end
        end
        expected_count = predicted_responses.size();
    end

endmodule

// ----- test/tb_caesar_request_responder_core.sv -----
// ----------------------------------------------------------------------------
// Caesar request responder core testbench
// Streams directed and random requests through the core under random input
// and output idling, across several length limits; a separate checker
// predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module tb_caesar_request_responder_core;

    import crr_pkg::*;

    // Generous ceiling on the run length in clock cycles.
    localparam int CYCLE_LIMIT = 200000;

    // Cycles allowed after the last expected result before the core is
    // considered idle; the result queue is only a few entries deep.
    localparam int SETTLE_CYCLES = 8;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_write_en   = 1'b0;
    logic [31:0] cfg_write_data = '0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic [7:0]  request_byte   = '0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic        out_kind;
    logic [7:0]  out_byte;
    logic [1:0]  out_status;
    logic [15:0] out_checksum;
    logic        out_last;

    int          mismatch_count;
    int          awaited_results;
    int          cycle_count    = 0;
    int          bytes_sent     = 0;

    // When set, the corresponding side runs without idling for a while.
    bit          steady_in      = 1'b0;
    bit          steady_out     = 1'b0;

    // Length limit currently held by the core, mirrored for the stimulus.
    logic [31:0] length_setting = MAX_LENGTH_DEFAULT;

    // Payload of the request being assembled.
    logic [7:0]  payload_q[$];

    caesar_request_responder_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .request_byte   (request_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_kind       (out_kind),
        .out_byte       (out_byte),
        .out_status     (out_status),
        .out_checksum   (out_checksum),
        .out_last       (out_last)
    );

    crr_response_checker u_response_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .request_byte   (request_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_kind       (out_kind),
        .out_byte       (out_byte),
        .out_status     (out_status),
        .out_checksum   (out_checksum),
        .out_last       (out_last),
        .error_count    (mismatch_count),
        .expected_count (awaited_results)
    );

    // Clock with a 12-unit period, starting low.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: a run that has not finished by the limit is a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Occasionally switches a side between random idling and full rate, so
    // that long stretches without any gaps occur as well.
    function automatic int draw_gap(ref bit steady);
        if ($urandom_range(0, 99) < 3)
        begin
            steady = !steady;
        end
        return steady ? 0 : $urandom_range(0, 3);
    endfunction

    // One's-complement sum used to build a matching request checksum.
    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // Payload bytes lean towards letters of both cases and the characters just
    // outside the letter ranges, where the case folding and rotation bite.
    function automatic logic [7:0] payload_char();
        logic [7:0] edges[4];
        edges = '{8'h40, 8'h5B, 8'h60, 8'h7B};
        case ($urandom_range(0, 5))
            0, 1:    return CHAR_UPPER_A + 8'($urandom_range(0, 25));
            2, 3:    return CHAR_LOWER_A + 8'($urandom_range(0, 25));
            4:       return edges[$urandom_range(0, 3)];
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Receiver: before each result transfer it may stall for a gap from draw_gap,
    // then holds stall low until a transfer takes place. Stall changes only at the
    // falling edge; transfers are observed at the rising edge.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap(steady_out);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid);
            @(negedge clk);
        end
    end

    // Offers one request byte after an idle gap from draw_gap and waits for its
    // transfer. Valid is left high on return so that back-to-back bytes do not
    // drop it in between; it is only lowered at the start of an idle gap.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap(steady_in);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        request_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Sends a header followed by whatever is in payload_q. The checksum field
    // matches the request unless a mismatch is wanted, in which case it is
    // spoilt by a random non-zero pattern.
    task automatic send_request(input logic [7:0] op, input logic [7:0] shift,
                                input logic [31:0] total_len, input bit spoil);
        logic [15:0] sum;
        logic [15:0] csum;
        logic [7:0]  low;
        int          i;
        sum = fold_add(16'd0, {op, shift});
        sum = fold_add(sum, total_len[31:16]);
        sum = fold_add(sum, total_len[15:0]);
        for (i = 0; i < payload_q.size(); i += 2)
        begin
            low = (i + 1 < payload_q.size()) ? payload_q[i + 1] : 8'h00;
            sum = fold_add(sum, {payload_q[i], low});
        end
        csum = ~sum;
        if (spoil)
        begin
            csum = csum ^ 16'($urandom_range(1, 16'hFFFF));
        end
        send_byte(op);
        send_byte(shift);
        send_byte(csum[15:8]);
        send_byte(csum[7:0]);
        send_byte(total_len[31:24]);
        send_byte(total_len[23:16]);
        send_byte(total_len[15:8]);
        send_byte(total_len[7:0]);
        foreach (payload_q[j])
        begin
            send_byte(payload_q[j]);
        end
        payload_q.delete();
    endtask

    // Mostly well-formed requests with random content; the rest are checksum
    // mismatches, unknown ops and lengths outside the accepted window.
    task automatic random_request();
        int          pick;
        int unsigned span;
        int unsigned n;
        logic [31:0] total;
        logic [7:0]  op;
        pick = $urandom_range(0, 99);
        op   = ($urandom_range(0, 1) == 0) ? OP_ENCODE : OP_DECODE;
        if (pick < 80)
        begin
            // Payload sizes stay small; only the limit itself is ever larger.
            span = ((length_setting - HEADER_BYTES) > 48) ? 48 : (length_setting - HEADER_BYTES);
            if ($urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(0, span);
            end
            else
            begin
                n = $urandom_range(0, (span > 12) ? 12 : span);
            end
            if ($urandom_range(0, 19) == 0)
            begin
                n = span;
            end
            repeat (n) payload_q.push_back(payload_char());
            send_request(op, 8'($urandom), HEADER_BYTES + n, pick >= 70);
        end
        else if (pick < 90)
        begin
            send_request(8'($urandom_range(2, 255)), 8'($urandom), $urandom, 1'b0);
        end
        else
        begin
            if (length_setting == 32'hFFFF_FFFF || $urandom_range(0, 1) == 0)
            begin
                total = $urandom_range(0, 7);
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                total = length_setting + 1;
            end
            else
            begin
                total = $urandom_range(length_setting + 1, 32'hFFFF_FFFF);
            end
            send_request(op, 8'($urandom), total, 1'b0);
        end
    endtask

    // Stops offering bytes, waits until every predicted result has been
    // transferred and then lets the core settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (awaited_results != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_length_limit(input logic [31:0] value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        length_setting  = value;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    task automatic run_random(input int target);
        while (bytes_sent < target)
        begin
            random_request();
        end
    endtask

    initial
    begin
        // Reset is held low and released at a falling edge.
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests under the reset length limit.
        // Encode with a zero key: bytes pass untouched, odd payload length.
        payload_q = '{8'h41, 8'h7B, 8'h7A};
        send_request(OP_ENCODE, 8'h00, 32'd11, 1'b0);
        // Decode with the most negative shift and no payload at all.
        send_request(OP_DECODE, 8'h80, 32'd8, 1'b0);
        // Decode with the largest positive shift across the alphabet ends.
        payload_q = '{8'h5A, 8'h61};
        send_request(OP_DECODE, 8'h7F, 32'd10, 1'b0);
        // Checksum mismatch: the bytes still stream before the summary.
        payload_q = '{8'h40, 8'h4D};
        send_request(OP_ENCODE, 8'h03, 32'd10, 1'b1);
        // Unknown op with every length bit set.
        send_request(8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b0);
        // Lengths just below the header size and just above the limit.
        send_request(OP_ENCODE, 8'h01, 32'd7, 1'b0);
        send_request(OP_DECODE, 8'h01, MAX_LENGTH_DEFAULT + 1, 1'b0);
        drain();

        // Random traffic under several length limits, the extremes included.
        run_random(330);
        drain();
        write_length_limit(HEADER_BYTES);
        run_random(560);
        drain();
        write_length_limit(32'hFFFF_FFFF);
        run_random(880);
        drain();
        write_length_limit(HEADER_BYTES + $urandom_range(1, 30));
        run_random(1120);
        drain();
        write_length_limit($urandom_range(64, 32'hFFFF_FFFE));
        run_random(1330);
        drain();

        if (mismatch_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
